/* rtl/ccp_pkg.sv */
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types and constants for the coefficient compress/pack/compare block.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int unsigned COEFF_W    = 13;
  localparam int unsigned NUM_COEFF  = 8;
  localparam int unsigned CBITS_W    = 4;
  localparam int unsigned COMP_W     = 11;
  localparam int unsigned PACK_W     = 88;
  localparam int unsigned LO_W       = 64;
  localparam int unsigned HI_W       = 24;
  localparam int unsigned MISM_W     = 8;
  localparam int unsigned BCNT_W     = 4;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  // Modulus and compression constants
  localparam int          MODULUS    = 3329;
  localparam int unsigned RED_W      = 12;
  localparam int unsigned NUM_W      = 23;
  localparam int unsigned RECIP_W    = 24;
  localparam int unsigned PROD_W     = NUM_W + RECIP_W;
  localparam int unsigned RECIP_SH   = 35;
  // ceil(2^35 / MODULUS): exact floor division for any 23-bit numerator
  localparam logic [RECIP_W-1:0] RECIP = 24'd10321340;
  localparam logic [NUM_W-1:0]   HALF_Q = NUM_W'(MODULUS / 2);
  localparam logic [COMP_W-1:0]  MASK_WIDE   = 11'h7ff;
  localparam logic [COMP_W-1:0]  MASK_NARROW = 11'h3ff;

  // Mode codes and byte counts
  localparam logic [CBITS_W-1:0] CBITS_WIDE   = 4'd11;
  localparam logic [CBITS_W-1:0] CBITS_RESET  = 4'd10;
  localparam logic [BCNT_W-1:0]  BYTES_WIDE   = 4'd11;
  localparam logic [BCNT_W-1:0]  BYTES_NARROW = 4'd5;
  localparam int unsigned        NARROW_BITS  = 40;

  // Register indexes (paddr[2])
  localparam logic REG_COEFF_BITS   = 1'b0;
  localparam logic REG_COMPARE_MODE = 1'b1;

  typedef struct packed {
    logic [CBITS_W-1:0] coeff_bits;
    logic               compare_mode;
  } ccp_cfg_t;

  typedef struct packed {
    logic [NUM_COEFF-1:0][COEFF_W-1:0] coeff;
    logic [LO_W-1:0]                   expected_lo;
    logic [HI_W-1:0]                   expected_hi;
    logic                              last_group;
  } ccp_in_t;

  typedef struct packed {
    logic [LO_W-1:0]   packed_lo;
    logic [HI_W-1:0]   packed_hi;
    logic [BCNT_W-1:0] byte_count;
    logic [MISM_W-1:0] mismatch;
    logic              vector_done;
  } ccp_out_t;

endpackage

/* rtl/ccp_if.sv */
// ----------------------------------------------------------------------------
// ccp_in_if / ccp_out_if
// Valid/ready channels carrying coefficient groups in and packed results out.
// ----------------------------------------------------------------------------
interface ccp_in_if;
  import ccp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COEFF_W-1:0] coeff0;
  logic signed [COEFF_W-1:0] coeff1;
  logic signed [COEFF_W-1:0] coeff2;
  logic signed [COEFF_W-1:0] coeff3;
  logic signed [COEFF_W-1:0] coeff4;
  logic signed [COEFF_W-1:0] coeff5;
  logic signed [COEFF_W-1:0] coeff6;
  logic signed [COEFF_W-1:0] coeff7;
  logic [LO_W-1:0]           expected_lo;
  logic [HI_W-1:0]           expected_hi;
  logic                      last_group;

  modport source (
    output valid, coeff0, coeff1, coeff2, coeff3, coeff4, coeff5, coeff6, coeff7,
    output expected_lo, expected_hi, last_group,
    input  ready
  );
  modport sink (
    input  valid, coeff0, coeff1, coeff2, coeff3, coeff4, coeff5, coeff6, coeff7,
    input  expected_lo, expected_hi, last_group,
    output ready
  );
endinterface

interface ccp_out_if;
  import ccp_pkg::*;

  logic              valid;
  logic              ready;
  logic [LO_W-1:0]   packed_lo;
  logic [HI_W-1:0]   packed_hi;
  logic [BCNT_W-1:0] byte_count;
  logic [MISM_W-1:0] mismatch;
  logic              vector_done;

  modport source (
    output valid, packed_lo, packed_hi, byte_count, mismatch, vector_done,
    input  ready
  );
  modport sink (
    input  valid, packed_lo, packed_hi, byte_count, mismatch, vector_done,
    output ready
  );
endinterface

/* rtl/ccp_apb_regs.sv */
// ----------------------------------------------------------------------------
// ccp_apb_regs
// APB register file holding the coefficient width and the compare mode.
// ----------------------------------------------------------------------------
module ccp_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccp_pkg::APB_AW-1:0] paddr,
  input  logic [ccp_pkg::APB_DW-1:0] pwdata,
  output logic [ccp_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output ccp_pkg::ccp_cfg_t          cfg_o
);
  import ccp_pkg::*;

  ccp_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  logic     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Decode the write request
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_COEFF_BITS:   cfg_d.coeff_bits   = pwdata[CBITS_W-1:0];
        REG_COMPARE_MODE: cfg_d.compare_mode = pwdata[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeff_bits   <= CBITS_RESET;
      cfg_q.compare_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_COEFF_BITS:   prdata = APB_DW'(cfg_q.coeff_bits);
      REG_COMPARE_MODE: prdata = APB_DW'(cfg_q.compare_mode);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/ccp_lane.sv */
// ----------------------------------------------------------------------------
// ccp_lane
// One coefficient: reduce into [0, q), compress to round(x*2^d/q), mask to d.
// ----------------------------------------------------------------------------
module ccp_lane (
  input  logic [ccp_pkg::COEFF_W-1:0] coeff_i,
  input  logic                        wide_i,
  output logic [ccp_pkg::COMP_W-1:0]  comp_o
);
  import ccp_pkg::*;

  logic signed [COEFF_W:0] x_s;
  logic signed [COEFF_W:0] x_red_s;
  logic [RED_W-1:0]        x_red;
  logic [NUM_W-1:0]        num;
  logic [PROD_W-1:0]       prod;
  logic [COMP_W:0]         quot;

  // Fold any 13-bit value into [0, q)
  always_comb begin
    x_s = {coeff_i[COEFF_W-1], coeff_i};
    if (x_s < -(COEFF_W+1)'(MODULUS)) begin
      x_red_s = x_s + (COEFF_W+1)'(2 * MODULUS);
    end else if (x_s < 0) begin
      x_red_s = x_s + (COEFF_W+1)'(MODULUS);
    end else if (x_s >= (COEFF_W+1)'(MODULUS)) begin
      x_red_s = x_s - (COEFF_W+1)'(MODULUS);
    end else begin
      x_red_s = x_s;
    end
    x_red = x_red_s[RED_W-1:0];
  end

  // Rounded numerator, then divide by q through the reciprocal
  always_comb begin
    if (wide_i) begin
      num = {x_red, 11'b0} + HALF_Q;
    end else begin
      num = {1'b0, x_red, 10'b0} + HALF_Q;
    end
    prod = PROD_W'(num) * PROD_W'(RECIP);
    quot = prod[PROD_W-1:RECIP_SH];
  end

  // Wrap the top value to zero
  assign comp_o = quot[COMP_W-1:0] & (wide_i ? MASK_WIDE : MASK_NARROW);

endmodule

/* rtl/coeff_compress_pack_compare_top.sv */
// ----------------------------------------------------------------------------
// coeff_compress_pack_compare_top
// Compresses a coefficient group, packs it into bytes and optionally checks
// it against expected bytes, accumulating a mismatch byte per vector.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | carries
//  ----------+-----------+--------------------+-------------------------------
//  in_ch     | in        | valid/ready        | coeff0..7, expected, last_group
//  out_ch    | out       | valid/ready        | packed bytes, count, mismatch
//  apb       | in        | psel/penable/pready| coeff_bits, compare_mode
//
//  Two register stages: input register, then result register; compression,
//  packing and compare sit between them (one multiplier per lane).
//  One request per cycle sustained while out_ch is not stalling.
//  Stalls on out_ch back up through the result register into in_ch.ready.
//  Reset clears valids, mismatch byte, compare_mode; coeff_bits resets to 10.
// ----------------------------------------------------------------------------
module coeff_compress_pack_compare_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ccp_in_if.sink                     in_ch,
  ccp_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccp_pkg::APB_AW-1:0] paddr,
  input  logic [ccp_pkg::APB_DW-1:0] pwdata,
  output logic [ccp_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import ccp_pkg::*;

  ccp_cfg_t          cfg;
  logic              wide;
  logic              in_valid_q;
  ccp_in_t           in_data_q, in_data_d;
  logic              out_valid_q;
  ccp_out_t          out_data_q, out_data_d;
  logic [MISM_W-1:0] acc_q, acc_d;
  logic              out_free;
  logic              adv;
  logic              take;
  logic [COMP_W-1:0] comp [NUM_COEFF];
  logic [PACK_W-1:0] pack;
  logic [PACK_W-1:0] expect_bytes;
  logic [PACK_W-1:0] diff;
  logic [MISM_W-1:0] diff_or;
  logic [MISM_W-1:0] acc_or;

  ccp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign wide = (cfg.coeff_bits == CBITS_WIDE);

  // Flow control
  assign out_free    = !out_valid_q || out_ch.ready;
  assign adv         = in_valid_q && out_free;
  assign in_ch.ready = !in_valid_q || out_free;
  assign take        = in_ch.valid && in_ch.ready;

  // Capture the request
  always_comb begin
    in_data_d.coeff[0]    = in_ch.coeff0;
    in_data_d.coeff[1]    = in_ch.coeff1;
    in_data_d.coeff[2]    = in_ch.coeff2;
    in_data_d.coeff[3]    = in_ch.coeff3;
    in_data_d.coeff[4]    = in_ch.coeff4;
    in_data_d.coeff[5]    = in_ch.coeff5;
    in_data_d.coeff[6]    = in_ch.coeff6;
    in_data_d.coeff[7]    = in_ch.coeff7;
    in_data_d.expected_lo = in_ch.expected_lo;
    in_data_d.expected_hi = in_ch.expected_hi;
    in_data_d.last_group  = in_ch.last_group;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_data_q <= in_data_d;
    end
  end

  // Compress each coefficient
  for (genvar g = 0; g < NUM_COEFF; g++) begin : g_lane
    ccp_lane u_lane (
      .coeff_i (in_data_q.coeff[g]),
      .wide_i  (wide),
      .comp_o  (comp[g])
    );
  end

  // Pack little-endian and line up the expected bytes
  always_comb begin
    if (wide) begin
      pack = {comp[7], comp[6], comp[5], comp[4], comp[3], comp[2], comp[1], comp[0]};
      expect_bytes = {in_data_q.expected_hi, in_data_q.expected_lo};
    end else begin
      pack = PACK_W'({comp[3][9:0], comp[2][9:0], comp[1][9:0], comp[0][9:0]});
      expect_bytes = PACK_W'(in_data_q.expected_lo[NARROW_BITS-1:0]);
    end
  end

  // Fold the byte differences into one byte
  always_comb begin
    diff    = pack ^ expect_bytes;
    diff_or = '0;
    for (int i = 0; i < PACK_W / 8; i++) begin
      diff_or = diff_or | diff[i*8 +: 8];
    end
    acc_or = acc_q | diff_or;
  end

  // Update the running mismatch; drop it after the last group
  always_comb begin
    acc_d = acc_q;
    if (adv) begin
      if (cfg.compare_mode) begin
        acc_d = acc_or;
      end
      if (in_data_q.last_group) begin
        acc_d = '0;
      end
    end
  end

  // Assemble the result
  always_comb begin
    out_data_d.packed_lo   = pack[LO_W-1:0];
    out_data_d.packed_hi   = pack[PACK_W-1:LO_W];
    out_data_d.byte_count  = wide ? BYTES_WIDE : BYTES_NARROW;
    out_data_d.mismatch    = cfg.compare_mode ? acc_or : '0;
    out_data_d.vector_done = in_data_q.last_group;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      acc_q <= acc_d;
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.packed_lo   = out_data_q.packed_lo;
  assign out_ch.packed_hi   = out_data_q.packed_hi;
  assign out_ch.byte_count  = out_data_q.byte_count;
  assign out_ch.mismatch    = out_data_q.mismatch;
  assign out_ch.vector_done = out_data_q.vector_done;

  // Checks
  a_narrow_zero_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.byte_count == BYTES_NARROW) |->
      (out_ch.packed_hi == '0 && out_ch.packed_lo[LO_W-1:NARROW_BITS] == '0))
    else $error("narrow result carries bits above byte four");

  a_no_compare_no_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !cfg.compare_mode) |-> (out_ch.mismatch == '0))
    else $error("mismatch reported with compare off");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_data_q.last_group) |=> (acc_q == '0))
    else $error("mismatch byte not cleared after last group");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_ch.valid)
    else $error("advanced request did not reach the result register");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives coefficient groups through coeff_compress_pack_compare_top under
// random source gaps and sink stalls. A directed pass covers wrap-around,
// out-of-range inputs, ignored lanes and bytes, and mismatch accumulation.
// Random vectors follow in several register settings, and every result is
// checked field by field against the predictor or a directed expected value.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ccp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_GROUPS   = 193;
  localparam int NUM_PHASES     = 10;

  typedef struct {
    logic [NUM_COEFF-1:0][COEFF_W-1:0] coeff;
    logic [LO_W-1:0]                   exp_lo;
    logic [HI_W-1:0]                   exp_hi;
    logic                              last;
    logic [CBITS_W-1:0]                bits;
    logic                              cmp;
    bit                                gold_on;
    ccp_out_t                          gold;
  } group_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  ccp_in_if  in_ch ();
  ccp_out_if out_ch ();

  // Register copies, running mismatch byte and pending results
  logic [CBITS_W-1:0] cfg_bits = CBITS_RESET;
  logic               cfg_cmp  = 1'b0;
  logic [MISM_W-1:0]  mism_acc = '0;
  ccp_out_t           pending_packs[$];
  group_t             directed_groups[$];
  int                 errors       = 0;
  int                 results_seen = 0;
  int                 send_calm    = 0;
  int                 idle_cycles  = 0;

  coeff_compress_pack_compare_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  task automatic report(input string what, input logic [87:0] got, input logic [87:0] want);
    if (errors < 40) begin
      $display("[%0t] MISMATCH %s: got %h want %h", $time, what, got, want);
    end
    errors++;
  endtask

  // Compress each lane to round(x * 2^d / q) mod 2^d and pack little-endian
  function automatic logic [87:0] pack_coeffs(input logic [NUM_COEFF-1:0][COEFF_W-1:0] cf,
                                               input bit wide);
    logic [87:0]       pk;
    logic [COMP_W-1:0] t;
    int                x;
    int unsigned       num;
    int                d;
    int                n;
    pk = '0;
    d  = wide ? 11 : 10;
    n  = wide ? 8 : 4;
    for (int k = 0; k < n; k++) begin
      x = $signed(cf[k]);
      x = x % MODULUS;
      if (x < 0) begin
        x += MODULUS;
      end
      num = (x << d) + MODULUS / 2;
      t   = COMP_W'(num / MODULUS) & (wide ? MASK_WIDE : MASK_NARROW);
      pk |= 88'(t) << (d * k);
    end
    return pk;
  endfunction

  // Predict one result and advance the running mismatch byte
  function automatic ccp_out_t predict_group(input group_t g);
    ccp_out_t    res;
    logic [87:0] pk;
    logic [87:0] want;
    logic [87:0] diff;
    logic [7:0]  or_b;
    bit          wide;
    wide = (cfg_bits == CBITS_WIDE);
    pk   = pack_coeffs(g.coeff, wide);
    res.packed_lo   = pk[63:0];
    res.packed_hi   = pk[87:64];
    res.byte_count  = wide ? BYTES_WIDE : BYTES_NARROW;
    res.mismatch    = '0;
    res.vector_done = g.last;
    if (cfg_cmp) begin
      want = {g.exp_hi, g.exp_lo};
      if (!wide) begin
        want[87:NARROW_BITS] = '0;
      end
      diff = pk ^ want;
      or_b = '0;
      for (int i = 0; i < 11; i++) begin
        or_b |= diff[8*i +: 8];
      end
      mism_acc |= or_b;
      res.mismatch = mism_acc;
    end
    if (g.last) begin
      mism_acc = '0;
    end
    return res;
  endfunction

  function automatic ccp_out_t mk_pack(input logic [63:0] lo, input logic [23:0] hi,
                                       input logic [3:0] cnt, input logic [7:0] mism,
                                       input logic done);
    ccp_out_t o;
    o.packed_lo   = lo;
    o.packed_hi   = hi;
    o.byte_count  = cnt;
    o.mismatch    = mism;
    o.vector_done = done;
    return o;
  endfunction

  function automatic void add_row(input logic [3:0] bits, input logic cmp,
                                  input logic [NUM_COEFF-1:0][COEFF_W-1:0] cf,
                                  input logic [63:0] elo, input logic [23:0] ehi,
                                  input logic last, input bit gold_on, input ccp_out_t gold);
    group_t g;
    g.coeff   = cf;
    g.exp_lo  = elo;
    g.exp_hi  = ehi;
    g.last    = last;
    g.bits    = bits;
    g.cmp     = cmp;
    g.gold_on = gold_on;
    g.gold    = gold;
    directed_groups.push_back(g);
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      v = int'($urandom_range(0, 6656)) - 3328;
    end else if (r < 88) begin
      case ($urandom_range(0, 6))
        0: v = -3328;
        1: v = -1;
        2: v = 0;
        3: v = 1;
        4: v = 1664;
        5: v = 1665;
        default: v = 3328;
      endcase
    end else begin
      v = $urandom;
    end
    return COEFF_W'(v);
  endfunction

  function automatic int pick_gap();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Offer one request, wait for acceptance, then record its prediction
  task automatic send_group(input group_t g);
    int       gap;
    ccp_out_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.coeff0      <= g.coeff[0];
    in_ch.coeff1      <= g.coeff[1];
    in_ch.coeff2      <= g.coeff[2];
    in_ch.coeff3      <= g.coeff[3];
    in_ch.coeff4      <= g.coeff[4];
    in_ch.coeff5      <= g.coeff[5];
    in_ch.coeff6      <= g.coeff[6];
    in_ch.coeff7      <= g.coeff[7];
    in_ch.expected_lo <= g.exp_lo;
    in_ch.expected_hi <= g.exp_hi;
    in_ch.last_group  <= g.last;
    in_ch.valid       <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = predict_group(g);
    pending_packs.push_back(g.gold_on ? g.gold : pred);
  endtask

  // Drop valid and wait until every pending result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_packs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_reg(input logic idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      report(idx == REG_COEFF_BITS ? "coeff_bits readback" : "compare_mode readback",
             88'(prdata), 88'(want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register with random upper bits, then read it back
  task automatic set_reg(input logic idx, input logic [31:0] val, input logic [31:0] mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~mask) | (val & mask);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_COEFF_BITS) begin
      cfg_bits = val[CBITS_W-1:0];
    end else begin
      cfg_cmp = val[0];
    end
    @(posedge clk_i);
    check_reg(idx, val & mask);
  endtask

  // Sink side: random stalls, calm stretches and one long hold-off
  initial begin
    int   stall;
    int   calm;
    int   hold_left;
    bit   held;
    int   r;
    logic rdy;
    stall     = 0;
    calm      = 0;
    hold_left = 0;
    held      = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rdy = 1'b1;
      if (!held && results_seen >= 300) begin
        held      = 1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall > 0) begin
        stall--;
        rdy = 1'b0;
      end else if (calm > 0) begin
        calm--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          calm = $urandom_range(20, 60);
        end else if (r < 5) begin
          stall = $urandom_range(15, 40);
          rdy   = 1'b0;
        end else if (r < 30) begin
          stall = $urandom_range(0, 2);
          rdy   = 1'b0;
        end
      end
      out_ch.ready <= rdy;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    ccp_out_t got;
    ccp_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.packed_lo   = out_ch.packed_lo;
      got.packed_hi   = out_ch.packed_hi;
      got.byte_count  = out_ch.byte_count;
      got.mismatch    = out_ch.mismatch;
      got.vector_done = out_ch.vector_done;
      results_seen++;
      if (pending_packs.size() == 0) begin
        report("result with nothing pending", 88'(got.packed_lo), '0);
      end else begin
        want = pending_packs.pop_front();
        if (got.packed_lo !== want.packed_lo) begin
          report("packed_lo", 88'(got.packed_lo), 88'(want.packed_lo));
        end
        if (got.packed_hi !== want.packed_hi) begin
          report("packed_hi", 88'(got.packed_hi), 88'(want.packed_hi));
        end
        if (got.byte_count !== want.byte_count) begin
          report("byte_count", 88'(got.byte_count), 88'(want.byte_count));
        end
        if (got.mismatch !== want.mismatch) begin
          report("mismatch", 88'(got.mismatch), 88'(want.mismatch));
        end
        if (got.vector_done !== want.vector_done) begin
          report("vector_done", 88'(got.vector_done), 88'(want.vector_done));
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("coeff_compress_pack_compare_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    group_t             g;
    logic [87:0]        pk;
    logic [87:0]        want;
    logic [CBITS_W-1:0] nb;
    logic               nc;
    bit                 wide;
    int                 sent;
    int                 vlen;
    int                 r;

    // Hold every input at a known value through reset
    in_ch.valid       <= 1'b0;
    in_ch.coeff0      <= '0;
    in_ch.coeff1      <= '0;
    in_ch.coeff2      <= '0;
    in_ch.coeff3      <= '0;
    in_ch.coeff4      <= '0;
    in_ch.coeff5      <= '0;
    in_ch.coeff6      <= '0;
    in_ch.coeff7      <= '0;
    in_ch.expected_lo <= '0;
    in_ch.expected_hi <= '0;
    in_ch.last_group  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;

    // Narrow mode straight out of reset: zero, wrap to zero, ignored lanes
    add_row(10, 0, '0, '1, '1, 0, 1, mk_pack(0, 0, BYTES_NARROW, 0, 0));
    add_row(10, 0, {8{13'h0d00}}, 0, 0, 0, 1, mk_pack(0, 0, BYTES_NARROW, 0, 0));
    add_row(10, 0, {8{13'h1300}}, 0, 0, 0, 1, mk_pack(0, 0, BYTES_NARROW, 0, 0));
    add_row(10, 0, {8{13'h1fff}}, 0, 0, 1, 1, mk_pack(0, 0, BYTES_NARROW, 0, 1));
    add_row(10, 0, {13'h1555, 13'h0aaa, 13'h1aaa, 13'h0555,
                    13'h0fff, 13'h1000, 13'h0d01, 13'h0001}, 0, 0, 0, 0, '0);
    add_row(10, 0, {{4{13'h1fff}}, {4{13'h0000}}}, 0, 0, 0, 1,
            mk_pack(0, 0, BYTES_NARROW, 0, 0));
    add_row(10, 0, {{4{13'h0000}}, 13'h0680, 13'h0681, 13'h0340, 13'h0002}, 0, 0, 1, 0, '0);
    // Narrow compare: ignored bytes, running OR, clear after the last group
    add_row(10, 1, '0, 64'hffff_ff00_0000_0000, 24'hffffff, 0, 1,
            mk_pack(0, 0, BYTES_NARROW, 0, 0));
    add_row(10, 1, '0, 64'h01, 0, 0, 1, mk_pack(0, 0, BYTES_NARROW, 8'h01, 0));
    add_row(10, 1, '0, 64'h0000_0080_0000_0000, 0, 1, 1,
            mk_pack(0, 0, BYTES_NARROW, 8'h81, 1));
    add_row(10, 1, '0, 0, 0, 0, 1, mk_pack(0, 0, BYTES_NARROW, 0, 0));
    add_row(10, 1, {13'h0100, 13'h1e00, 13'h0333, 13'h1abc,
                    13'h0c00, 13'h0400, 13'h1800, 13'h0123},
            64'h1234_5678_9abc_def0, 24'h00aa55, 1, 0, '0);
    // Any coeff_bits value other than the wide code selects narrow packing
    add_row(15, 0, {8{13'h0d00}}, 0, 0, 1, 1, mk_pack(0, 0, BYTES_NARROW, 0, 1));
    add_row(0, 1, '0, 0, 24'hffffff, 1, 1, mk_pack(0, 0, BYTES_NARROW, 0, 1));
    // Wide mode: zero, all-ones extremes, out-of-range lanes
    add_row(11, 0, '0, 0, 0, 0, 1, mk_pack(0, 0, BYTES_WIDE, 0, 0));
    add_row(11, 0, {8{13'h0d00}}, 0, 0, 0, 1, mk_pack('1, '1, BYTES_WIDE, 0, 0));
    add_row(11, 0, {8{13'h1fff}}, 0, 0, 1, 1, mk_pack('1, '1, BYTES_WIDE, 0, 1));
    add_row(11, 0, {13'h1000, 13'h0fff, 13'h0d01, 13'h1300,
                    13'h0681, 13'h0680, 13'h0001, 13'h0aaa}, 0, 0, 0, 0, '0);
    // Wide compare; a last group with compare off still clears the byte
    add_row(11, 1, {8{13'h0d00}}, '1, '1, 0, 1, mk_pack('1, '1, BYTES_WIDE, 0, 0));
    add_row(11, 1, {8{13'h0d00}}, '1, 24'h7fffff, 0, 1,
            mk_pack('1, '1, BYTES_WIDE, 8'h80, 0));
    add_row(11, 0, '0, 0, 0, 1, 1, mk_pack(0, 0, BYTES_WIDE, 0, 1));
    add_row(11, 1, '0, 0, 0, 1, 1, mk_pack(0, 0, BYTES_WIDE, 0, 1));
    add_row(11, 1, {13'h1555, 13'h0aaa, 13'h1555, 13'h0aaa,
                    13'h1555, 13'h0aaa, 13'h1555, 13'h0aaa}, 0, 0, 0, 0, '0);
    add_row(11, 1, {13'h0fed, 13'h1234, 13'h0777, 13'h1888,
                    13'h0003, 13'h1ffe, 13'h0d00, 13'h1300},
            64'hfedc_ba98_7654_3210, 24'h5a5a5a, 1, 0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_reg(REG_COEFF_BITS, 32'(CBITS_RESET));
    check_reg(REG_COMPARE_MODE, 32'h0);

    // Walk the directed rows, reprogramming only when idle
    foreach (directed_groups[i]) begin
      g = directed_groups[i];
      if (g.bits != cfg_bits || g.cmp != cfg_cmp) begin
        drain();
        if (g.bits != cfg_bits) set_reg(REG_COEFF_BITS, 32'(g.bits), 32'hf);
        if (g.cmp != cfg_cmp) set_reg(REG_COMPARE_MODE, 32'(g.cmp), 32'h1);
      end
      send_group(g);
    end

    // Random vectors, one register setting per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin nb = CBITS_RESET; nc = 1'b0; end
        1: begin nb = CBITS_WIDE;  nc = 1'b1; end
        2: begin nb = 4'd0;        nc = 1'b1; end
        3: begin nb = 4'd15;       nc = 1'b0; end
        4: begin nb = CBITS_WIDE;  nc = 1'b0; end
        5: begin nb = CBITS_RESET; nc = 1'b1; end
        default: begin
          nb = $urandom_range(0, 1) ? CBITS_WIDE : CBITS_W'($urandom_range(0, 15));
          nc = 1'($urandom_range(0, 1));
        end
      endcase
      drain();
      set_reg(REG_COEFF_BITS, 32'(nb), 32'hf);
      set_reg(REG_COMPARE_MODE, 32'(nc), 32'h1);
      wide = (cfg_bits == CBITS_WIDE);
      sent = 0;
      while (sent < PHASE_GROUPS) begin
        vlen = $urandom_range(1, 12);
        for (int j = 0; j < vlen; j++) begin
          for (int k = 0; k < NUM_COEFF; k++) begin
            g.coeff[k] = pick_coeff();
          end
          pk   = pack_coeffs(g.coeff, wide);
          want = 88'({$urandom, $urandom, $urandom});
          // Mostly matching bytes, some with one flipped bit, the rest noise
          if (cfg_cmp) begin
            r = $urandom_range(0, 99);
            if (r < 90) begin
              if (wide) begin
                want = pk;
              end else begin
                want[NARROW_BITS-1:0] = pk[NARROW_BITS-1:0];
              end
              if (r >= 70) begin
                want[$urandom_range(0, wide ? 87 : NARROW_BITS - 1)] ^= 1'b1;
              end
            end
          end
          g.exp_lo  = want[63:0];
          g.exp_hi  = want[87:64];
          g.last    = (j == vlen - 1);
          g.bits    = cfg_bits;
          g.cmp     = cfg_cmp;
          g.gold_on = 0;
          g.gold    = '0;
          send_group(g);
          sent++;
        end
      end
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (errors == 0) begin
      $display("coeff_compress_pack_compare_top verification clean");
    end else begin
      $display("coeff_compress_pack_compare_top verification failed");
    end
    $finish;
  end

endmodule

/* coeff_compress_pack_compare_top.f */
rtl/ccp_pkg.sv
rtl/ccp_if.sv
rtl/ccp_apb_regs.sv
rtl/ccp_lane.sv
rtl/coeff_compress_pack_compare_top.sv
sim/testbench.sv
